// ===== rtl/cln_pkg.sv =====
// ----------------------------------------------------------------------------
// cln_pkg - shared types and constants for the command line normaliser
// Character codes, line phase encoding and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package cln_pkg;

    // Raw characters after the first MAX_LINE-1 of a line are ignored (range 2 to 256)
    localparam int MAX_LINE = 256;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POUND = 8'h23;

    // Line phase
    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_DROP = 2'd2
    } t_phase;

    // One accepted character's worth of results: up to three characters,
    // a count of zero with last set stands for a bare end marker
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] chars;
        logic            last;
    } t_entry;

endpackage

// ===== rtl/cln_if.sv =====
// ----------------------------------------------------------------------------
// cln_if - valid/ready channels of the command line normaliser
// Input channel carries raw characters, output channel normalised results.
// ----------------------------------------------------------------------------
interface cln_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       line_end;

    modport source (output valid, output in_char, output line_end, input ready);
    modport sink   (input valid, input in_char, input line_end, output ready);
endinterface

interface cln_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_line;

    modport source (output valid, output out_char, output has_char,
                    output end_of_line, input ready);
    modport sink   (input valid, input out_char, input has_char,
                    input end_of_line, output ready);
endinterface

// ===== rtl/command_line_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// command_line_normalizer_top - command line whitespace and comment cleaner
// Takes raw command line characters and gives the normalised line.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one raw character per beat, line_end set on the last of a line.
//   o_out : normalised characters; has_char is clear only on a bare end
//           marker, end_of_line marks the last result of every line.
// Throughput: one input beat per cycle while the queue has room; the output
//   side gives one result per cycle while o_out.ready is high, so a beat
//   that releases two or three characters (held space and slash plus the
//   new character) takes one emitter result per character. The four-entry
//   queue absorbs such bursts.
// Path: an accepted beat is written into the queue, then the output register
//   loads its first character; each further character of the same beat
//   follows in order.
// Reset: synchronous, active low; clears line state, queue and output valid.
// Stall: while o_out.ready is low the output register holds its beat; the
//   front keeps accepting until the queue fills, then drops i_in.ready.
// ----------------------------------------------------------------------------
module command_line_normalizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cln_in_if.sink    i_in,
    cln_out_if.source o_out
);
    import cln_pkg::*;

    logic   push, q_full, pop, q_valid;
    t_entry push_entry, head_entry;

    cln_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    cln_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_entry)
    );

    cln_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/cln_front.sv =====
// ----------------------------------------------------------------------------
// cln_front - character classifier and line state
// Accepts one raw character a cycle while the queue has room, updates the
// line state and pushes the characters it releases as one queue entry.
// ----------------------------------------------------------------------------
module cln_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cln_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output cln_pkg::t_entry o_entry
);
    import cln_pkg::*;

    localparam logic [8:0] LIMIT = 9'(MAX_LINE - 1);

    t_phase     r_phase, n_phase;
    logic       r_sp, n_sp;
    logic       r_sl, n_sl;
    logic [7:0] r_pos, n_pos;

    logic            accept;
    logic [7:0]      c;
    logic            counted;
    logic            handled;
    logic [1:0]      cnt;
    logic [3:0][7:0] chars;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // Classify the beat and work out next state and released characters
    always_comb begin
        n_phase = r_phase;
        n_sp    = r_sp;
        n_sl    = r_sl;
        n_pos   = (r_pos != 8'hFF) ? r_pos + 8'd1 : r_pos;
        cnt     = 2'd0;
        chars   = '0;
        handled = 1'b0;
        c       = (i_in.in_char == CH_TAB) ? CH_SPACE : i_in.in_char;
        counted = ({1'b0, r_pos} < LIMIT);

        if (counted && (r_phase == PH_LEAD || r_phase == PH_BODY)) begin
            // resolve a held slash first
            if (r_sl) begin
                n_sl = 1'b0;
                if (c == CH_SLASH) begin
                    n_phase = PH_DROP;
                    n_sp    = 1'b0;
                    handled = 1'b1;
                end else begin
                    if (r_sp) begin
                        chars[cnt] = CH_SPACE;
                        cnt        = cnt + 2'd1;
                        n_sp       = 1'b0;
                    end
                    chars[cnt] = CH_SLASH;
                    cnt        = cnt + 2'd1;
                end
            end
            if (!handled) begin
                if (c < CH_SPACE || c > CH_TILDE) begin
                    // cut the line, drop any trailing space
                    n_phase = PH_DROP;
                    n_sp    = 1'b0;
                end else if (c == CH_SPACE) begin
                    if (r_phase == PH_BODY) begin
                        n_sp = 1'b1;
                    end
                end else if (r_phase == PH_LEAD && c == CH_POUND) begin
                    n_phase = PH_DROP;
                end else if (c == CH_SLASH) begin
                    n_sl    = 1'b1;
                    n_phase = PH_BODY;
                end else begin
                    if (n_sp) begin
                        chars[cnt] = CH_SPACE;
                        cnt        = cnt + 2'd1;
                        n_sp       = 1'b0;
                    end
                    chars[cnt] = c;
                    cnt        = cnt + 2'd1;
                    n_phase    = PH_BODY;
                end
            end
        end

        // flush a held slash at the end of the line, then clear the state
        if (i_in.line_end) begin
            if (n_sl) begin
                if (n_sp) begin
                    chars[cnt] = CH_SPACE;
                    cnt        = cnt + 2'd1;
                end
                chars[cnt] = CH_SLASH;
                cnt        = cnt + 2'd1;
            end
            n_phase = PH_LEAD;
            n_sp    = 1'b0;
            n_sl    = 1'b0;
            n_pos   = 8'd0;
        end
    end

    // Push only beats that release something or close the line
    assign o_push        = accept && (cnt != 2'd0 || i_in.line_end);
    assign o_entry.cnt   = cnt;
    assign o_entry.chars = chars[2:0];
    assign o_entry.last  = i_in.line_end;

    // Advance line state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_sp    <= 1'b0;
            r_sl    <= 1'b0;
            r_pos   <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_sp    <= n_sp;
            r_sl    <= n_sl;
            r_pos   <= n_pos;
        end
    end

endmodule

// ===== rtl/cln_queue.sv =====
// ----------------------------------------------------------------------------
// cln_queue - short queue between front and back
// Holds released entries so the classifier and the emitter stall apart.
// ----------------------------------------------------------------------------
module cln_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cln_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cln_pkg::t_entry o_head
);
    import cln_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Write the entry store
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/cln_back.sv =====
// ----------------------------------------------------------------------------
// cln_back - result emitter
// Walks the characters of the queue head one per beat into an output
// register, marking the last result of each line.
// ----------------------------------------------------------------------------
module cln_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  cln_pkg::t_entry i_head,
    output logic            o_pop,
    cln_out_if.source       o_out
);
    import cln_pkg::*;

    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_has;
    logic       r_eol;

    logic       load;
    logic       at_last;
    logic [1:0] top_idx;
    logic [7:0] sel_char;

    assign load    = i_q_valid && (!r_ov || o_out.ready);
    assign top_idx = (i_head.cnt == 2'd0) ? 2'd0 : i_head.cnt - 2'd1;
    assign at_last = (r_idx == top_idx);
    assign o_pop   = load && at_last;

    // Select the character at the walk index
    always_comb begin
        case (r_idx)
            2'd0:    sel_char = i_head.chars[0];
            2'd1:    sel_char = i_head.chars[1];
            2'd2:    sel_char = i_head.chars[2];
            default: sel_char = 8'd0;
        endcase
    end

    // Hold the walk index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
                r_ov  <= 1'b1;
            end else if (o_out.ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_has  <= (i_head.cnt != 2'd0);
            r_char <= (i_head.cnt != 2'd0) ? sel_char : 8'd0;
            r_eol  <= i_head.last && at_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_char    = r_char;
    assign o_out.has_char    = r_has;
    assign o_out.end_of_line = r_eol;

endmodule

// ===== rtl/cln_checker.sv =====
// ----------------------------------------------------------------------------
// cln_checker - port level checks for the command line normaliser
// Watches the output channel for marker and character rules.
// ----------------------------------------------------------------------------
module cln_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_has_char,
    input logic       i_out_eol
);

    // A beat without a character is always a line end marker
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has_char |-> i_out_eol && i_out_char == 8'd0)
        else $error("bare result beat is not an end marker");

    // Characters sent are printable
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_has_char |-> i_out_char >= 8'h20 && i_out_char <= 8'h7E)
        else $error("non-printable character sent");

    // A line never ends on a space
    a_no_trailing_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eol && i_out_has_char |-> i_out_char != 8'h20)
        else $error("line ends with a space");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_has_char) && $stable(i_out_eol))
        else $error("stalled beat changed");

endmodule

bind command_line_normalizer_top cln_checker u_cln_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_has_char (o_out.has_char),
    .i_out_eol      (o_out.end_of_line)
);
